[hw/rtl/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants and divider handshake types for the centered moving
// average core.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

	// ring depth, must be a power of two
	localparam int MAX_WINDOW = 64;
	localparam int FRAC_BITS  = 16;

	localparam int SAMPLE_W   = 32;
	localparam int WIN_W      = 7;
	localparam int AVG_W      = 48;
	localparam int WIN_RESET  = 2;

	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int W_W        = $clog2(MAX_WINDOW + 1);
	localparam int SEEN_W     = $clog2(MAX_WINDOW + 2);
	localparam int SEEN_MAX   = MAX_WINDOW + 1;
	localparam int SUM_W      = SAMPLE_W + PTR_W;

	// quotient bits resolved per divider cycle
	localparam int RADIX_BITS = 8;
	localparam int DVD_W      = SUM_W + FRAC_BITS;
	localparam int DIV_CYC    = (DVD_W + RADIX_BITS - 1) / RADIX_BITS;
	localparam int PAD_W      = DIV_CYC * RADIX_BITS;
	localparam int CNT_W      = $clog2(DIV_CYC + 1);

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] sum;
		logic [W_W-1:0]          divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             valid;
		logic [AVG_W-1:0] value;
	} div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/centered_moving_average_core.sv]
// ----------------------------------------------------------------------------
// centered_moving_average_core
// Centered boxcar moving average of a signed sample stream, fixed-point mean
// with a flush of the pending positions on the last sample.
// A new sample is taken only once every result of the last one, and for the
// last sample of a run every flushed zero and mean, has reached the output
// register. The mean divider resolves 8 quotient bits per cycle.
// Reset: async, clears run state and sets the window size to its reset value; sample RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_moving_average_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cma_pkg::WIN_W-1:0]    cfg_wdata,      // window_size
	input  wire logic                         s_axis_tvalid,
	output      logic                         s_axis_tready,
	input  wire logic [cma_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
	input  wire logic                         s_axis_tlast,
	output      logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output      logic [cma_pkg::AVG_W-1:0]    m_axis_tdata,   // [47:0] average
	output      logic                         m_axis_tlast
);

	import cma_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_UPD  = 4'b0010,
		S_EMIT = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		SRC_OLD,
		SRC_FLUSH,
		SRC_ALT
	} src_t;

	state_t                     state_q;
	logic [WIN_W-1:0]           window_q;
	logic [PTR_W-1:0]           ptr_q;
	logic [SEEN_W-1:0]          seen_q;
	logic [SEEN_W-1:0]          seen_old_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_old_q;
	logic signed [SUM_W-1:0]    fsum_q;
	logic signed [SUM_W-1:0]    s2_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       last_q;
	logic                       norm_pend_q;
	logic                       norm_div_q;
	logic                       flush_pend_q;
	logic                       full_q;
	logic [PTR_W-1:0]           r_q;
	logic                       eor_q;
	logic                       out_valid_q;
	logic [AVG_W-1:0]           out_data_q;
	logic                       out_last_q;

	logic [W_W-1:0]             w_eff;
	logic [W_W-1:0]             off;
	logic [W_W-1:0]             lag;
	logic [SEEN_W-1:0]          w_s;
	logic [SEEN_W-1:0]          lag_s;
	logic [SEEN_W-1:0]          k_cnt;
	logic                       accept;
	logic                       out_free;
	logic                       ram_re;
	logic [PTR_W-1:0]           ram_raddr;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] add_v;
	logic signed [SAMPLE_W-1:0] sub_v;
	logic signed [SUM_W-1:0]    sum_new;
	logic                       emit_any;
	logic                       emit_div;
	logic                       emit_eor;
	logic                       hit_s;
	logic                       hit_alt;
	src_t                       emit_src;
	logic                       zero_wr;
	logic                       div_wr;
	logic                       advance;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	// effective window and derived spans
	always_comb begin
		if (window_q < WIN_W'(WIN_RESET)) begin
			w_eff = W_W'(WIN_RESET);
		end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
			w_eff = W_W'(MAX_WINDOW);
		end else begin
			w_eff = W_W'(window_q);
		end
	end

	assign off   = w_eff >> 1;
	assign lag   = w_eff - off;
	assign w_s   = SEEN_W'(w_eff);
	assign lag_s = SEEN_W'(lag);
	assign k_cnt = (seen_q < lag_s) ? seen_q : lag_s;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// oldest window sample on transfer, odd-window flush term in update
	assign ram_re    = accept || (state_q == S_UPD);
	assign ram_raddr = (state_q == S_UPD) ? (ptr_q - PTR_W'(w_eff - 1'b1))
	                                      : (ptr_q - PTR_W'(w_eff));

	cma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (ptr_q),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// running sum update
	always_comb begin
		if (w_eff[0]) begin
			add_v = (seen_old_q != '0) ? prev_q : '0;
		end else begin
			add_v = x_q;
		end
		sub_v   = (seen_old_q >= w_s) ? $signed(ram_rdata) : '0;
		sum_new = sum_q + SUM_W'(add_v) - SUM_W'(sub_v);
	end

	// next result selection
	always_comb begin
		hit_s    = full_q && ((W_W'(r_q) + 1'b1) == lag);
		hit_alt  = full_q && w_eff[0] && ((W_W'(r_q) + 1'b1) == off);
		emit_any = norm_pend_q || flush_pend_q;
		if (norm_pend_q) begin
			emit_div = norm_div_q;
			emit_src = SRC_OLD;
			emit_eor = 1'b0;
		end else begin
			emit_div = hit_s || hit_alt;
			emit_src = hit_s ? SRC_FLUSH : SRC_ALT;
			emit_eor = (r_q == '0);
		end
	end

	always_comb begin
		div_req.start   = (state_q == S_EMIT) && emit_any && emit_div;
		div_req.divisor = off << 1;
		case (emit_src)
			SRC_OLD:   div_req.sum = sum_old_q;
			SRC_FLUSH: div_req.sum = fsum_q;
			default:   div_req.sum = s2_q;
		endcase
	end

	cma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign zero_wr = (state_q == S_EMIT) && emit_any && !emit_div && out_free;
	assign div_wr  = (state_q == S_DIV) && div_rsp.valid && out_free;
	assign advance = (state_q == S_EMIT) && emit_any && (emit_div || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			window_q     <= WIN_W'(WIN_RESET);
			ptr_q        <= '0;
			seen_q       <= '0;
			sum_q        <= '0;
			norm_pend_q  <= 1'b0;
			flush_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_UPD;
						ptr_q       <= ptr_q + 1'b1;
						seen_q      <= (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q
						                                             : seen_q + 1'b1;
						norm_pend_q <= (seen_q >= lag_s);
					end
				end
				S_UPD: begin
					state_q      <= S_EMIT;
					flush_pend_q <= last_q;
					if (last_q) begin
						ptr_q  <= '0;
						seen_q <= '0;
						sum_q  <= '0;
					end else begin
						sum_q <= sum_new;
					end
				end
				S_EMIT: begin
					if (!emit_any) begin
						state_q <= S_IDLE;
					end else if (emit_div) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_wr) begin
						state_q <= S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (advance) begin
				if (norm_pend_q) begin
					norm_pend_q <= 1'b0;
				end else if (r_q == '0) begin
					flush_pend_q <= 1'b0;
				end
			end

			if (zero_wr || div_wr) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				window_q <= cfg_wdata;
				ptr_q    <= '0;
				seen_q   <= '0;
				sum_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= $signed(s_axis_tdata);
			last_q     <= s_axis_tlast;
			seen_old_q <= seen_q;
			sum_old_q  <= sum_q;
			norm_div_q <= (seen_q >= w_s);
		end
		if (state_q == S_UPD) begin
			prev_q <= x_q;
			fsum_q <= sum_new;
			full_q <= (seen_q > w_s);
			r_q    <= PTR_W'(k_cnt - 1'b1);
		end
		// read data and operands hold for the whole flush
		s2_q <= fsum_q - SUM_W'($signed(ram_rdata)) + SUM_W'(x_q);
		if (advance) begin
			eor_q <= emit_eor;
			if (!norm_pend_q && r_q != '0) begin
				r_q <= r_q - 1'b1;
			end
		end
		if (zero_wr) begin
			out_data_q <= '0;
			out_last_q <= emit_eor;
		end else if (div_wr) begin
			out_data_q <= div_rsp.value;
			out_last_q <= eor_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!div_rsp.busy && !norm_pend_q && !flush_pend_q))
		else $error("input ready with results still pending");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_rsp.busy || div_rsp.valid))
		else $error("waiting on divider that holds no job");

	a_upd_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("sum update without an input transfer");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(zero_wr || div_wr) |=> m_axis_tvalid)
		else $error("result load lost");

endmodule

`default_nettype wire

[hw/rtl/cma_ram.sv]
// ----------------------------------------------------------------------------
// cma_ram
// Generic simple dual-port RAM, one write and one read port, registered
// read data, read-first on an address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cma_div.sv]
// ----------------------------------------------------------------------------
// cma_div
// Signed sum to fixed-point mean: magnitude shifted by the fraction bits,
// restoring division by the divisor (twice the half window), several quotient bits per cycle,
// sign restored and truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cma_pkg::div_req_t req,
	output      cma_pkg::div_rsp_t rsp
);

	import cma_pkg::*;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIX  = 3'b100
	} div_state_t;

	div_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PAD_W-1:0] dvd_q;
	logic [W_W-1:0]   rem_q;
	logic [W_W-1:0]   n_q;
	logic             neg_q;
	logic             valid_q;
	logic [AVG_W-1:0] value_q;

	logic [SUM_W-1:0] mag;
	logic [PAD_W-1:0] dvd_n;
	logic [W_W-1:0]   rem_n;
	logic [W_W:0]     trial;
	logic [AVG_W-1:0] quo;

	assign mag = req.sum[SUM_W-1] ? (SUM_W'(0) - req.sum) : req.sum;
	assign quo = dvd_q[AVG_W-1:0];

	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		trial = '0;
		for (int i = 0; i < RADIX_BITS; i++) begin
			trial = {rem_n, dvd_n[PAD_W-1]};
			dvd_n = {dvd_n[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, n_q}) begin
				rem_n    = W_W'(trial - {1'b0, n_q});
				dvd_n[0] = 1'b1;
			end else begin
				rem_n = trial[W_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						valid_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					valid_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			dvd_q <= PAD_W'(mag) << FRAC_BITS;
			rem_q <= '0;
			n_q   <= req.divisor;
			neg_q <= req.sum[SUM_W-1];
		end else if (state_q == D_RUN) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (state_q == D_FIX) begin
			value_q <= neg_q ? (AVG_W'(0) - quo) : quo;
		end
	end

	assign rsp.busy  = (state_q != D_IDLE);
	assign rsp.valid = valid_q;
	assign rsp.value = value_q;

endmodule

`default_nettype wire

[bench/centered_moving_average_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average_core_tb
// Streams runs of signed samples through the centered moving average core
// under changing window settings and random backpressure. An in-bench
// predictor computes every window mean and every flush output, and each
// result transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module centered_moving_average_core_tb;
	import cma_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 55;

	typedef struct packed {
		logic [AVG_W-1:0] average;
		logic             end_of_run;
	} mean_result_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [WIN_W-1:0]    cfg_wdata     = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
	logic                s_axis_tlast  = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [AVG_W-1:0]    m_axis_tdata;
	logic                m_axis_tlast;

	// predictor state
	logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
	int                         hist_wp  = 0;
	int                         run_len  = 0;
	longint                     win_sum  = 0;
	logic [WIN_W-1:0]           win_cfg  = WIN_W'(WIN_RESET);
	mean_result_t               expected_means [$];

	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int mismatches      = 0;
	int samples_in      = 0;
	int results_checked = 0;
	int runs_done       = 0;
	int windows_set     = 0;
	int cycle_count     = 0;
	bit abandon_pending = 1'b0;

	centered_moving_average_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_means.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int eff_window();
		int w;
		w = int'(win_cfg);
		if (w < 2) w = 2;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	function automatic longint hist_back(input int d);
		return longint'(hist[(hist_wp + MAX_WINDOW - d) % MAX_WINDOW]);
	endfunction

	// truncation toward zero of sum / n in fixed point
	function automatic logic [AVG_W-1:0] fixed_mean(input longint s, input int n);
		longint unsigned mag;
		longint unsigned q;
		mag = (s < 0) ? longint'(-s) : s;
		q = (mag << FRAC_BITS) / longint'(n);
		if (s < 0) q = -q;
		return q[AVG_W-1:0];
	endfunction

	function automatic void clear_run();
		hist_wp = 0;
		run_len = 0;
		win_sum = 0;
	endfunction

	function automatic void predict_sample(input logic [SAMPLE_W-1:0] din, input logic fin);
		int           w;
		int           off;
		int           n;
		int           lag;
		int           k;
		bit           full;
		longint       x;
		longint       s;
		mean_result_t r;
		w   = eff_window();
		off = w / 2;
		n   = 2 * off;
		lag = w - off;
		x   = longint'($signed(din));
		if (run_len >= lag) begin
			r.average    = (run_len >= w) ? fixed_mean(win_sum, n) : '0;
			r.end_of_run = 1'b0;
			expected_means.push_back(r);
		end
		if (run_len >= w - n) win_sum += (w == n) ? x : hist_back(1);
		if (run_len >= w) win_sum -= hist_back(w);
		hist[hist_wp] = din;
		hist_wp = (hist_wp + 1) % MAX_WINDOW;
		if (run_len < MAX_WINDOW + 1) run_len++;
		samples_in++;
		if (fin) begin
			k    = (run_len < lag) ? run_len : lag;
			full = run_len > w;
			s    = win_sum;
			for (int i = k - 1; i >= 0; i--) begin
				r.average = '0;
				if (full && i + 1 >= off) begin
					if (i + 1 == lag) r.average = fixed_mean(s, n);
					else r.average = fixed_mean(s - hist_back(w - 1) + hist_back(1), n);
				end
				r.end_of_run = (i == 0);
				expected_means.push_back(r);
			end
			clear_run();
			runs_done++;
		end
	endfunction

	function automatic void check_result();
		mean_result_t exp_r;
		if (expected_means.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result average=%h last=%b", $time, m_axis_tdata,
				m_axis_tlast);
			return;
		end
		exp_r = expected_means.pop_front();
		results_checked++;
		if (m_axis_tdata !== exp_r.average) begin
			mismatches++;
			$display("%0t: average expected %h actual %h", $time, exp_r.average, m_axis_tdata);
		end
		if (m_axis_tlast !== exp_r.end_of_run) begin
			mismatches++;
			$display("%0t: end_of_run expected %b actual %b", $time, exp_r.end_of_run,
				m_axis_tlast);
		end
	endfunction

	// model update and result check on every transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				win_cfg = cfg_wdata;
				clear_run();
			end
			if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) check_result();
		end
	end

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			2: return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
			default: return $urandom_range(1) ? 32'h7fff_ff00 | $urandom_range(255)
				: 32'h8000_0000 | $urandom_range(255);
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] din, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= din;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_run(input int len, input bit fin);
		for (int i = 0; i < len; i++) send_sample(rand_sample(), fin && (i == len - 1));
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		windows_set++;
	endtask

	task automatic test_default_window();
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'hffff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		hold_until_drained();
	endtask

	task automatic test_window_clamp();
		write_window(7'd0);
		send_run(3, 1'b1);
		hold_until_drained();
		write_window(7'd1);
		send_sample(32'h0000_0001, 1'b1);
		hold_until_drained();
		write_window(7'd127);
		send_run(2, 1'b1);
		hold_until_drained();
	endtask

	task automatic test_short_run();
		write_window(7'd9);
		send_run(3, 1'b1);
		hold_until_drained();
	endtask

	// window write mid run drops the pending outputs, then an odd window run
	task automatic test_abandoned_run();
		write_window(7'd4);
		send_run(3, 1'b0);
		hold_until_drained();
		write_window(7'd5);
		send_run(7, 1'b1);
		hold_until_drained();
	endtask

	task automatic test_random_runs(input int goal);
		int               sent;
		int               w_eff;
		int               len;
		int               pick;
		bit               broken;
		logic [WIN_W-1:0] value;
		sent = 0;
		while (sent < goal) begin
			if (abandon_pending || $urandom_range(2) != 0) begin
				hold_until_drained();
				pick = $urandom_range(19);
				if (pick == 0) value = WIN_W'($urandom_range(1));
				else if (pick <= 2) value = WIN_W'($urandom_range(127, 32));
				else value = WIN_W'($urandom_range(12, 2));
				write_window(value);
			end
			w_eff = eff_window();
			if (w_eff >= 16) begin
				if ($urandom_range(1)) len = $urandom_range(3, 1);
				else len = w_eff + $urandom_range(6, 1);
			end else begin
				len = $urandom_range(3 * w_eff + 4, 1);
			end
			broken = ($urandom_range(7) == 0);
			send_run(len, !broken);
			sent += len;
			abandon_pending = broken;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 64;
		test_default_window();
		test_window_clamp();
		test_short_run();
		test_abandoned_run();
		test_random_runs(RANDOM_ITEMS);

		send_idle_pct = 64;
		recv_idle_pct = 19;
		test_random_runs(RANDOM_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_runs(RANDOM_ITEMS);
		hold_until_drained();

		$display("run covered %0d samples in %0d complete runs with %0d window writes",
			samples_in, runs_done, windows_set);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/cma_pkg.sv
hw/rtl/cma_ram.sv
hw/rtl/cma_div.sv
hw/rtl/centered_moving_average_core.sv
bench/centered_moving_average_core_tb.sv
